>>> sv/brle_pkg.sv
// Shared types, codes and helpers of the bitmap RLE span decoder.
// No dependencies; every other file of the block but brle_if imports this package.
`default_nettype none

package brle_pkg;

    // Colour store geometry
    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);

    // Low nibble mask for four-bit run coding
    localparam logic [3:0] NIB_MASK = 4'hF;

    // Input item actions
    localparam logic [1:0] ACT_PAL   = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TOP    = 2'd2;
    localparam logic [1:0] REG_NIBBLE = 2'd3;

    typedef struct packed {
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        top_down;
        logic        nibble_mode;
    } cfg_t;

    // Work handed from the parser to the palette and output stage
    typedef struct packed {
        logic        pal_we;
        logic [7:0]  pal_slot;
        logic [23:0] pal_rgb;
        logic        span;
        logic        done;
        logic [15:0] row;
        logic [15:0] col;
        logic [7:0]  len;
        logic [7:0]  even_idx;
        logic [7:0]  odd_idx;
    } span_req_t;

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/brle_if.sv
// Valid/ready channel interfaces of the bitmap RLE span decoder.
// Depends on nothing; used by the core, brle_parse and brle_out.
`default_nettype none

interface brle_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  palette_slot;
    logic [23:0] palette_rgb;
    logic [7:0]  stream_byte;

    modport source (output valid, action, palette_slot, palette_rgb, stream_byte,
                    input ready);
    modport sink   (input valid, action, palette_slot, palette_rgb, stream_byte,
                    output ready);
endinterface

interface brle_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_row;
    logic [15:0] out_col;
    logic [7:0]  span_len;
    logic [23:0] even_rgb;
    logic [23:0] odd_rgb;
    logic        image_done;

    modport source (output valid, out_row, out_col, span_len, even_rgb, odd_rgb,
                    image_done, input ready);
    modport sink   (input valid, out_row, out_col, span_len, even_rgb, odd_rgb,
                    image_done, output ready);
endinterface

`default_nettype wire

>>> sv/brle_cfg.sv
// APB-style configuration registers of the bitmap RLE span decoder.
// Depends on brle_pkg.
`default_nettype none

module brle_cfg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output brle_pkg::cfg_t cfg
);
    import brle_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= 16'd1;
            cfg_reg.image_height <= 16'd1;
            cfg_reg.top_down     <= 1'b0;
            cfg_reg.nibble_mode  <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_WIDTH:  cfg_reg.image_width  <= pwdata[15:0];
                REG_HEIGHT: cfg_reg.image_height <= pwdata[15:0];
                REG_TOP:    cfg_reg.top_down     <= pwdata[0];
                REG_NIBBLE: cfg_reg.nibble_mode  <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = {16'd0, cfg_reg.image_width};
            REG_HEIGHT: prdata = {16'd0, cfg_reg.image_height};
            REG_TOP:    prdata = {31'd0, cfg_reg.top_down};
            REG_NIBBLE: prdata = {31'd0, cfg_reg.nibble_mode};
            default:    prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

>>> sv/brle_parse.sv
// Input register and stream parser: pair decoding, cursor, runs, padding.
// Depends on brle_pkg and brle_in_if; feeds brle_out through span_req_t.
`default_nettype none

module brle_parse (
    input  logic                clk,
    input  logic                rst_n,
    input  brle_pkg::cfg_t      cfg,
    brle_in_if.sink             in_ch,
    input  logic                hold,
    output logic                adv,
    output brle_pkg::span_req_t req
);
    import brle_pkg::*;

    localparam logic [2:0] PH_FIRST  = 3'd0;
    localparam logic [2:0] PH_SECOND = 3'd1;
    localparam logic [2:0] PH_DX     = 3'd2;
    localparam logic [2:0] PH_DY     = 3'd3;
    localparam logic [2:0] PH_ABS    = 3'd4;
    localparam logic [2:0] PH_PAD    = 3'd5;

    // Input register
    logic        s1_valid_reg;
    logic [1:0]  s1_action_reg;
    logic [7:0]  s1_slot_reg;
    logic [23:0] s1_rgb_reg;
    logic [7:0]  s1_byte_reg;

    // Parser state
    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  held_reg, held_next;
    logic [7:0]  left_reg, left_next;
    logic        pad_reg, pad_next;
    logic        fin_reg, fin_next;

    logic        span_go;
    logic [7:0]  span_len;
    logic [7:0]  span_even;
    logic [7:0]  span_odd;
    logic [7:0]  b;
    logic [8:0]  b_inc;
    logic [7:0]  k;
    logic [15:0] room;
    logic [7:0]  vis_len;
    logic        vis_ok;

    assign in_ch.ready = ~s1_valid_reg | ~hold;
    assign adv         = s1_valid_reg & ~hold;
    assign b           = s1_byte_reg;
    assign b_inc       = {1'b0, b} + 9'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_action_reg <= in_ch.action;
            s1_slot_reg   <= in_ch.palette_slot;
            s1_rgb_reg    <= in_ch.palette_rgb;
            s1_byte_reg   <= in_ch.stream_byte;
        end
    end

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        phase_next = phase_reg;
        held_next  = held_reg;
        left_next  = left_reg;
        pad_next   = pad_reg;
        fin_next   = fin_reg;
        span_go    = 1'b0;
        span_len   = 8'd0;
        span_even  = b;
        span_odd   = b;
        k          = 8'd0;
        req          = '0;
        req.pal_slot = s1_slot_reg;
        req.pal_rgb  = s1_rgb_reg;

        unique case (s1_action_reg)
            ACT_PAL:
            begin
                req.pal_we = 1'b1;
            end
            ACT_START:
            begin
                col_next   = 16'd0;
                row_next   = 16'd0;
                phase_next = PH_FIRST;
                held_next  = 8'd0;
                left_next  = 8'd0;
                pad_next   = 1'b0;
                fin_next   = 1'b0;
            end
            ACT_BYTE:
            begin
                if (!fin_reg)
                begin
                    unique case (phase_reg)
                        PH_FIRST:
                        begin
                            held_next  = b;
                            phase_next = PH_SECOND;
                        end
                        PH_SECOND:
                        begin
                            phase_next = PH_FIRST;
                            if (held_reg != 8'd0)
                            begin
                                // encoded run
                                span_go  = 1'b1;
                                span_len = held_reg;
                                if (cfg.nibble_mode)
                                begin
                                    span_even = {4'd0, b[7:4] & NIB_MASK};
                                    span_odd  = {4'd0, b[3:0] & NIB_MASK};
                                end
                            end
                            else if (b == 8'd0)
                            begin
                                col_next = 16'd0;
                                row_next = sat_add16(row_reg, 16'd1);
                            end
                            else if (b == 8'd1)
                            begin
                                fin_next = 1'b1;
                                req.done = 1'b1;
                            end
                            else if (b == 8'd2)
                            begin
                                phase_next = PH_DX;
                            end
                            else
                            begin
                                // absolute run: padding fixed here
                                left_next  = b;
                                pad_next   = cfg.nibble_mode ? b_inc[1] : b[0];
                                phase_next = PH_ABS;
                            end
                        end
                        PH_DX:
                        begin
                            col_next   = sat_add16(col_reg, {8'd0, b});
                            phase_next = PH_DY;
                        end
                        PH_DY:
                        begin
                            row_next   = sat_add16(row_reg, {8'd0, b});
                            phase_next = PH_FIRST;
                        end
                        PH_ABS:
                        begin
                            if (cfg.nibble_mode)
                            begin
                                k         = (left_reg < 8'd2) ? left_reg : 8'd2;
                                span_even = {4'd0, b[7:4] & NIB_MASK};
                                span_odd  = {4'd0, b[3:0] & NIB_MASK};
                            end
                            else
                            begin
                                k = (left_reg < 8'd1) ? left_reg : 8'd1;
                            end
                            span_go   = 1'b1;
                            span_len  = k;
                            left_next = left_reg - k;
                            if (left_next == 8'd0)
                            begin
                                phase_next = pad_reg ? PH_PAD : PH_FIRST;
                            end
                        end
                        default:
                        begin
                            // drop the padding byte
                            phase_next = PH_FIRST;
                        end
                    endcase
                end
            end
            default: ;
        endcase

        // clip against the image and advance the cursor by the full count
        vis_ok  = (row_reg < cfg.image_height) && (col_reg < cfg.image_width);
        room    = cfg.image_width - col_reg;
        vis_len = ({8'd0, span_len} < room) ? span_len : room[7:0];
        if (span_go)
        begin
            col_next = sat_add16(col_reg, {8'd0, span_len});
        end
        req.span     = span_go & vis_ok & (vis_len != 8'd0);
        req.row      = cfg.top_down ? row_reg : (cfg.image_height - 16'd1 - row_reg);
        req.col      = col_reg;
        req.len      = vis_len;
        req.even_idx = span_even;
        req.odd_idx  = span_odd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= 16'd0;
            row_reg   <= 16'd0;
            phase_reg <= PH_FIRST;
            held_reg  <= 8'd0;
            left_reg  <= 8'd0;
            pad_reg   <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else if (adv)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            phase_reg <= phase_next;
            held_reg  <= held_next;
            left_reg  <= left_next;
            pad_reg   <= pad_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/brle_out.sv
// Colour store and result register: palette writes, two-port colour read,
// and the output item held until taken. Depends on brle_pkg and brle_out_if.
`default_nettype none

module brle_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  brle_pkg::span_req_t req,
    output logic                hold,
    brle_out_if.source          out_ch
);
    import brle_pkg::*;

    logic [23:0] colour_mem [PAL_DEPTH];

    logic        out_valid_reg;
    logic [15:0] row_reg;
    logic [15:0] col_reg;
    logic [7:0]  len_reg;
    logic        done_reg;
    logic [23:0] even_reg;
    logic [23:0] odd_reg;
    logic        even_ok_reg;
    logic        odd_ok_reg;
    logic        load;
    logic        slot_ok;
    logic        even_ok;
    logic        odd_ok;

    assign hold    = out_valid_reg & ~out_ch.ready;
    assign load    = adv & (req.span | req.done);
    assign slot_ok = int'(req.pal_slot) < PAL_DEPTH;
    assign even_ok = int'(req.even_idx) < PAL_DEPTH;
    assign odd_ok  = int'(req.odd_idx) < PAL_DEPTH;

    always_ff @(posedge clk)
    begin
        if (adv && req.pal_we && slot_ok)
        begin
            colour_mem[req.pal_slot[PAL_AW-1:0]] <= req.pal_rgb;
        end
        if (load)
        begin
            even_reg    <= colour_mem[req.even_idx[PAL_AW-1:0]];
            odd_reg     <= colour_mem[req.odd_idx[PAL_AW-1:0]];
            even_ok_reg <= even_ok & ~req.done;
            odd_ok_reg  <= odd_ok & ~req.done;
            row_reg     <= req.done ? 16'd0 : req.row;
            col_reg     <= req.done ? 16'd0 : req.col;
            len_reg     <= req.done ? 8'd0 : req.len;
            done_reg    <= req.done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= req.span | req.done;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_row    = row_reg;
    assign out_ch.out_col    = col_reg;
    assign out_ch.span_len   = len_reg;
    assign out_ch.even_rgb   = even_ok_reg ? even_reg : 24'd0;
    assign out_ch.odd_rgb    = odd_ok_reg ? odd_reg : 24'd0;
    assign out_ch.image_done = done_reg;

endmodule

`default_nettype wire

>>> sv/bmp_rle_span_decoder_core.sv
// Top level of the bitmap RLE8/RLE4 span decoder.
// Depends on brle_pkg, brle_if, brle_cfg, brle_parse and brle_out.
//
//  channel   dir  handshake            carries
//  in_ch     in   valid/ready          action, palette_slot, palette_rgb, stream_byte
//  out_ch    out  valid/ready          out_row, out_col, span_len, even_rgb, odd_rgb,
//                                      image_done
//  apb       in   psel/penable/pready  image_width, image_height, top_down, nibble_mode
//
// One item per cycle unless a result stalls; results pass the input and result registers.
// The parse state and the colour store port are updated once per item in the
// stage behind the input register; the colour read lands in the result register.
// Reset clears the cursor, parse state and valid flags; the colour store is
// not cleared. A stalled result holds the parser stage; the input register
// still takes an item while it is empty.
`default_nettype none

module bmp_rle_span_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    brle_in_if.sink     in_ch,
    brle_out_if.source  out_ch
);
    import brle_pkg::*;

    cfg_t      cfg;
    span_req_t req;
    logic      adv;
    logic      hold;

    brle_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    brle_parse u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .in_ch (in_ch),
        .hold  (hold),
        .adv   (adv),
        .req   (req)
    );

    brle_out u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .req    (req),
        .hold   (hold),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire

>>> bench/tb_bmp_rle_span_decoder_core.sv
// Self-checking bench for bmp_rle_span_decoder_core: RLE8/RLE4 streams go in, spans are
// checked against an in-bench decoder. Depends on brle_pkg, brle_if and the core RTL.
`timescale 1ns / 1ps

module tb_bmp_rle_span_decoder_core;
    import brle_pkg::*;

    localparam logic [1:0] ACT_NONE       = 2'd3;
    localparam logic [7:0] ESC_MARK       = 8'd0;
    localparam logic [7:0] ESC_EOL        = 8'd0;
    localparam logic [7:0] ESC_END        = 8'd1;
    localparam logic [7:0] ESC_DELTA      = 8'd2;
    localparam int         SETTLE_CYCLES  = 6;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         REPORT_LINES   = 100;

    typedef enum logic [2:0] {ST_LEAD, ST_CODE, ST_DX, ST_DY, ST_LITERAL, ST_PAD} pstate_t;

    typedef struct {
        logic [1:0]  action;
        logic [7:0]  slot;
        logic [23:0] rgb;
        logic [7:0]  data;
    } feed_t;

    typedef struct packed {
        logic [15:0] row;
        logic [15:0] col;
        logic [7:0]  len;
        logic [23:0] even;
        logic [23:0] odd;
        logic        done;
    } span_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    brle_in_if  in_bus ();
    brle_out_if out_bus ();

    bmp_rle_span_decoder_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_bus),
        .out_ch  (out_bus)
    );

    // Decoder copy: configuration, palette and cursor
    logic [15:0] cfg_w   = 16'd1;
    logic [15:0] cfg_h   = 16'd1;
    logic        cfg_top = 1'b0;
    logic        cfg_nib = 1'b0;
    logic [23:0] clut [PAL_DEPTH];
    logic [15:0] pen_col    = '0;
    logic [15:0] pen_row    = '0;
    pstate_t     pstate     = ST_LEAD;
    logic [7:0]  held_count = '0;
    logic [7:0]  lit_left   = '0;
    logic        lit_pad    = 1'b0;
    logic        bmp_over   = 1'b0;

    feed_t pending [$];
    span_t spans_due [$];

    int errors     = 0;
    int gap_left   = 0;
    int burst_left = 0;
    int sink_tick  = 0;
    int idle_count = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [15:0] clamp_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic [7:0] rnd_byte(input int lo, input int hi);
        return 8'($urandom_range(lo, hi));
    endfunction

    function automatic logic [23:0] rnd_rgb();
        return 24'($urandom_range(0, 32'h00FF_FFFF));
    endfunction

    task automatic report(input string what, input logic [31:0] want_v,
                          input logic [31:0] got_v);
        errors++;
        if (errors <= REPORT_LINES)
            $display("%0t ns: %s expected %0h got %0h", $time, what, want_v, got_v);
    endtask

    // Expect a span at the cursor if any of it is visible, then advance by the full count
    task automatic place_span(input logic [7:0] len, input logic [7:0] even_idx,
                              input logic [7:0] odd_idx);
        logic [16:0] room;
        logic [7:0]  vis;
        span_t       s;
        if (pen_row < cfg_h && pen_col < cfg_w)
        begin
            room = {1'b0, cfg_w} - {1'b0, pen_col};
            vis  = ({9'd0, len} < room) ? len : room[7:0];
            if (vis != 8'd0)
            begin
                s.row  = cfg_top ? pen_row : cfg_h - 16'd1 - pen_row;
                s.col  = pen_col;
                s.len  = vis;
                s.even = clut[even_idx];
                s.odd  = clut[odd_idx];
                s.done = 1'b0;
                spans_due.push_back(s);
            end
        end
        pen_col = clamp_add(pen_col, {8'd0, len});
    endtask

    task automatic decode_item(input logic [1:0] act, input logic [7:0] slot,
                               input logic [23:0] rgb, input logic [7:0] d);
        logic [8:0] half;
        logic [7:0] take;
        span_t      fin;
        case (act)
            ACT_PAL:
                clut[slot] = rgb;
            ACT_START:
            begin
                pen_col    = '0;
                pen_row    = '0;
                pstate     = ST_LEAD;
                held_count = '0;
                lit_left   = '0;
                lit_pad    = 1'b0;
                bmp_over   = 1'b0;
            end
            ACT_BYTE:
            begin
                if (!bmp_over)
                begin
                    case (pstate)
                        ST_LEAD:
                        begin
                            held_count = d;
                            pstate     = ST_CODE;
                        end
                        ST_CODE:
                        begin
                            pstate = ST_LEAD;
                            if (held_count != ESC_MARK)
                            begin
                                if (cfg_nib)
                                    place_span(held_count, {4'd0, d[7:4]}, {4'd0, d[3:0]});
                                else
                                    place_span(held_count, d, d);
                            end
                            else if (d == ESC_EOL)
                            begin
                                pen_col = '0;
                                pen_row = clamp_add(pen_row, 16'd1);
                            end
                            else if (d == ESC_END)
                            begin
                                bmp_over = 1'b1;
                                fin      = '0;
                                fin.done = 1'b1;
                                spans_due.push_back(fin);
                            end
                            else if (d == ESC_DELTA)
                                pstate = ST_DX;
                            else
                            begin
                                // padding is fixed here, even if the mode changes mid run
                                half     = {1'b0, d} + 9'd1;
                                lit_left = d;
                                lit_pad  = cfg_nib ? half[1] : d[0];
                                pstate   = ST_LITERAL;
                            end
                        end
                        ST_DX:
                        begin
                            pen_col = clamp_add(pen_col, {8'd0, d});
                            pstate  = ST_DY;
                        end
                        ST_DY:
                        begin
                            pen_row = clamp_add(pen_row, {8'd0, d});
                            pstate  = ST_LEAD;
                        end
                        ST_LITERAL:
                        begin
                            if (cfg_nib)
                            begin
                                take = (lit_left < 8'd2) ? lit_left : 8'd2;
                                place_span(take, {4'd0, d[7:4]}, {4'd0, d[3:0]});
                            end
                            else
                            begin
                                take = (lit_left < 8'd1) ? lit_left : 8'd1;
                                place_span(take, d, d);
                            end
                            lit_left = lit_left - take;
                            if (lit_left == 8'd0)
                                pstate = lit_pad ? ST_PAD : ST_LEAD;
                        end
                        default:
                            pstate = ST_LEAD;
                    endcase
                end
            end
            default:
                ;
        endcase
    endtask

    task automatic put_item(input logic [1:0] act, input logic [7:0] slot,
                            input logic [23:0] rgb, input logic [7:0] d);
        feed_t f;
        f.action = act;
        f.slot   = slot;
        f.rgb    = rgb;
        f.data   = d;
        pending.push_back(f);
    endtask

    task automatic put_data(input logic [7:0] d);
        put_item(ACT_BYTE, rnd_byte(0, 255), rnd_rgb(), d);
    endtask

    task automatic put_start();
        put_item(ACT_START, rnd_byte(0, 255), rnd_rgb(), rnd_byte(0, 255));
    endtask

    // Mostly well-formed pairs with random content, some noise and stray actions
    task automatic gen_random(input int total, input logic nib);
        int made;
        int pick;
        int n;
        int k;
        int pad;
        made = 0;
        while (made < total)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
            begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 16);
                put_data(8'(n));
                put_data(rnd_byte(0, 255));
                made += 2;
            end
            else if (pick < 58)
            begin
                n   = ($urandom_range(0, 24) == 0) ? $urandom_range(15, 255)
                                                   : $urandom_range(3, 14);
                k   = nib ? (n + 1) / 2 : n;
                pad = nib ? ((n + 1) / 2) % 2 : n % 2;
                put_data(ESC_MARK);
                put_data(8'(n));
                repeat (k + pad)
                    put_data(rnd_byte(0, 255));
                made += 2 + k + pad;
            end
            else if (pick < 70)
            begin
                put_data(ESC_MARK);
                put_data(ESC_EOL);
                made += 2;
            end
            else if (pick < 79)
            begin
                put_data(ESC_MARK);
                put_data(ESC_DELTA);
                put_data(($urandom_range(0, 9) == 0) ? rnd_byte(0, 255) : rnd_byte(0, 8));
                put_data(($urandom_range(0, 9) == 0) ? rnd_byte(0, 255) : rnd_byte(0, 3));
                made += 4;
            end
            else if (pick < 82)
            begin
                // end of bitmap, a few ignored bytes, then a fresh image
                put_data(ESC_MARK);
                put_data(ESC_END);
                repeat ($urandom_range(0, 3))
                    put_data(rnd_byte(0, 255));
                put_start();
                made += 3;
            end
            else if (pick < 87)
            begin
                put_item(ACT_PAL, rnd_byte(0, 255), rnd_rgb(), rnd_byte(0, 255));
                made += 1;
            end
            else if (pick < 89)
            begin
                put_start();
                made += 1;
            end
            else
            begin
                put_item(2'($urandom_range(0, 3)), rnd_byte(0, 255), rnd_rgb(),
                         rnd_byte(0, 255));
                made += 1;
            end
        end
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_w   = val[15:0];
            REG_HEIGHT: cfg_h   = val[15:0];
            REG_TOP:    cfg_top = val[0];
            REG_NIBBLE: cfg_nib = val[0];
            default:    ;
        endcase
    endtask

    task automatic program_cfg(input logic [15:0] w, input logic [15:0] h,
                               input logic top, input logic nib);
        cfg_write(REG_WIDTH, {16'd0, w});
        cfg_write(REG_HEIGHT, {16'd0, h});
        cfg_write(REG_TOP, {31'd0, top});
        cfg_write(REG_NIBBLE, {31'd0, nib});
        @(negedge clk);
    endtask

    // Hold off until every item is in and every span is out, then let the pipe drain
    task automatic settle();
        do
            @(negedge clk);
        while (pending.size() != 0 || in_bus.valid || spans_due.size() != 0);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // Sender: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin : feed_drive
        feed_t nxt;
        if (!rst_n)
            in_bus.valid <= 1'b0;
        else
        begin
            if (in_bus.valid && in_bus.ready)
                decode_item(in_bus.action, in_bus.palette_slot, in_bus.palette_rgb,
                            in_bus.stream_byte);
            if (!in_bus.valid || in_bus.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_bus.valid <= 1'b0;
                end
                else if (pending.size() != 0)
                begin
                    nxt = pending.pop_front();
                    in_bus.action       <= nxt.action;
                    in_bus.palette_slot <= nxt.slot;
                    in_bus.palette_rgb  <= nxt.rgb;
                    in_bus.stream_byte  <= nxt.data;
                    in_bus.valid        <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_bus.valid <= 1'b0;
            end
        end
    end

    // Receiver: check each span, stall on a rotating pattern
    always @(posedge clk or negedge rst_n)
    begin : span_check
        span_t want;
        if (!rst_n)
            out_bus.ready <= 1'b0;
        else
        begin
            if (out_bus.valid && out_bus.ready)
            begin
                if (spans_due.size() == 0)
                    report("span with none pending, out_col", 32'd0, 32'(out_bus.out_col));
                else
                begin
                    want = spans_due.pop_front();
                    if (out_bus.out_row !== want.row)
                        report("out_row", 32'(want.row), 32'(out_bus.out_row));
                    if (out_bus.out_col !== want.col)
                        report("out_col", 32'(want.col), 32'(out_bus.out_col));
                    if (out_bus.span_len !== want.len)
                        report("span_len", 32'(want.len), 32'(out_bus.span_len));
                    if (out_bus.even_rgb !== want.even)
                        report("even_rgb", 32'(want.even), 32'(out_bus.even_rgb));
                    if (out_bus.odd_rgb !== want.odd)
                        report("odd_rgb", 32'(want.odd), 32'(out_bus.odd_rgb));
                    if (out_bus.image_done !== want.done)
                        report("image_done", 32'(want.done), 32'(out_bus.image_done));
                end
            end
            sink_tick++;
            case (sink_tick[8:7])
                2'd0:    out_bus.ready <= 1'b1;
                2'd1:    out_bus.ready <= (sink_tick[1:0] != 2'd0);
                2'd2:    out_bus.ready <= 1'($urandom_range(0, 1));
                default: out_bus.ready <= (sink_tick[2:0] == 3'd0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
                idle_count <= 0;
            else if (idle_count >= WATCHDOG_LIMIT)
            begin
                $display("bmp_rle_span_decoder_core: mismatch");
                $finish;
            end
            else
                idle_count <= idle_count + 1;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        in_bus.valid        = 1'b0;
        in_bus.action       = ACT_BYTE;
        in_bus.palette_slot = '0;
        in_bus.palette_rgb  = '0;
        in_bus.stream_byte  = '0;
        out_bus.ready       = 1'b0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        // Bottom-first RLE8; fill the whole palette so no colour read hits an empty entry
        program_cfg(16'd16, 16'd8, 1'b0, 1'b0);
        put_item(ACT_PAL, 8'd0, 24'h000000, 8'd0);
        for (int s = 1; s < PAL_DEPTH - 1; s++)
            put_item(ACT_PAL, 8'(s), rnd_rgb(), rnd_byte(0, 255));
        put_item(ACT_PAL, 8'd255, 24'hFFFFFF, 8'd255);
        put_start();
        put_item(ACT_NONE, 8'hA5, 24'h5A5A5A, 8'h33);
        put_data(8'd5);
        put_data(8'd0);
        // run past the right edge: clipped
        put_data(8'd255);
        put_data(8'd255);
        put_data(ESC_MARK);
        put_data(ESC_EOL);
        put_data(ESC_MARK);
        put_data(ESC_DELTA);
        put_data(8'd3);
        put_data(8'd1);
        // odd absolute run with its pad byte
        put_data(ESC_MARK);
        put_data(8'd3);
        put_data(8'h10);
        put_data(8'h20);
        put_data(8'h30);
        put_data(8'h00);
        put_data(ESC_MARK);
        put_data(ESC_END);
        put_data(8'd1);
        put_item(ACT_PAL, 8'd16, rnd_rgb(), 8'd0);
        settle();

        // Top-first RLE4: two-colour run, absolute run needing a pad, end of bitmap
        program_cfg(16'd16, 16'd8, 1'b1, 1'b1);
        put_start();
        put_data(8'd7);
        put_data(8'h12);
        put_data(ESC_MARK);
        put_data(8'd5);
        put_data(8'h34);
        put_data(8'h56);
        put_data(8'h70);
        put_data(8'h00);
        put_data(ESC_MARK);
        put_data(ESC_END);
        settle();

        program_cfg(16'd40, 16'd12, 1'b1, 1'b0);
        put_start();
        gen_random(120, 1'b0);
        settle();

        program_cfg(16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
        put_start();
        gen_random(100, 1'b1);
        settle();

        // no fresh image: the stream carries on under the other coding
        program_cfg(16'd1, 16'd1, 1'b0, 1'b0);
        gen_random(40, 1'b0);
        settle();

        program_cfg(16'($urandom_range(1, 64)), 16'($urandom_range(1, 24)),
                    1'($urandom_range(0, 1)), 1'b1);
        put_start();
        gen_random(90, 1'b1);
        settle();

        program_cfg(16'd24, 16'($urandom_range(1, 40)), 1'b0, 1'b0);
        put_start();
        gen_random(90, 1'b0);
        settle();

        if (errors == 0)
            $display("bmp_rle_span_decoder_core: match");
        else
            $display("bmp_rle_span_decoder_core: mismatch");
        $finish;
    end

endmodule
